### hdl/ace_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ace_pkg
// Shared types and constants for the attribute closure engine.
// ----------------------------------------------------------------------------
package ace_pkg;

    localparam int ATTR_FW          = 26;
    localparam int IDX_FW           = 5;
    localparam int CNT_FW           = 6;
    localparam int CFG_IDX_W        = 2;
    localparam int DEP_DEPTH_DEF    = 32;
    localparam int ATTR_COUNT_DEF   = 26;

    localparam logic [CFG_IDX_W-1:0] CFG_RELATION_ATTRS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEP_COUNT      = 2'd1;

    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    typedef struct packed {
        logic               func;
        logic [IDX_FW-1:0]  entry_index;
        logic [ATTR_FW-1:0] left_attrs;
        logic [ATTR_FW-1:0] right_attrs;
    } ace_req_t;

    typedef struct packed {
        logic [ATTR_FW-1:0] closure_attrs;
        logic               is_superkey;
        logic               implies_right;
    } ace_rsp_t;

endpackage

### hdl/ace_dep_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ace_dep_table
// Dependency store: one word per entry holding left and right sides,
// single write port, registered read port.
// ----------------------------------------------------------------------------
module ace_dep_table
    import ace_pkg::*;
#(
    parameter int  DEP_DEPTH = DEP_DEPTH_DEF,
    parameter int  ATTR_W    = ATTR_COUNT_DEF,
    localparam int ADDR_W    = (DEP_DEPTH > 1) ? $clog2(DEP_DEPTH) : 1
)
(
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [ADDR_W-1:0]        wr_addr,
    input  logic [ATTR_W-1:0]        wr_left,
    input  logic [ATTR_W-1:0]        wr_right,
    input  logic                     rd_en,
    input  logic [ADDR_W-1:0]        rd_addr,
    output logic [ATTR_W-1:0]        rd_left,
    output logic [ATTR_W-1:0]        rd_right
);

    logic [2*ATTR_W-1:0] mem [DEP_DEPTH];
    logic [2*ATTR_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= {wr_left, wr_right};
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_left  = rd_data_reg[2*ATTR_W-1:ATTR_W];
    assign rd_right = rd_data_reg[ATTR_W-1:0];

endmodule

### hdl/attribute_closure_engine_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// attribute_closure_engine_core
// Attribute closure over a loaded table of functional dependencies.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: request is taken when start is high and busy is low.
//   func = write stores left/right at entry_index, no result.
//   func = query computes the closure of left_attrs; one result follows,
//   shown on result for a single cycle with done high. The receiver cannot
//   stall; the result register frees the block for the next item at once.
//   Config channel: cfg_valid/cfg_ready (always ready), cfg_index selects
//   relation attributes (0) or dependency count (1); other indexes ignored.
//   A query walks the first n entries (dependency count, capped at DEP_DEPTH)
//   in table passes until a pass adds no attribute; with n zero it answers
//   without a walk. Each pass streams the table through the single read port
//   of the dependency store, one entry a cycle, with the read registered.
//   Reset clears the registers and control state; table contents are kept
//   undefined until written.
// ----------------------------------------------------------------------------
module attribute_closure_engine_core
    import ace_pkg::*;
#(
    parameter int DEP_DEPTH  = DEP_DEPTH_DEF,
    parameter int ATTR_COUNT = ATTR_COUNT_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  ace_req_t             request,
    output logic                 done,
    output ace_rsp_t             result,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [ATTR_FW-1:0]   cfg_data
);

    localparam int ATTR_W = (ATTR_COUNT < ATTR_FW) ? ATTR_COUNT : ATTR_FW;
    localparam int ADDR_W = (DEP_DEPTH > 1) ? $clog2(DEP_DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEP_DEPTH + 1);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_WALK = 2'b10
    } state_t;

    state_t             state_reg, state_next;
    logic [ATTR_FW-1:0] rel_reg;
    logic [CNT_FW-1:0]  count_reg;
    logic [ATTR_W-1:0]  clo_reg, clo_next;
    logic [ATTR_W-1:0]  right_reg, right_next;
    logic [CNT_W-1:0]   n_reg, n_next;
    logic [ADDR_W-1:0]  idx_reg, idx_next;
    logic               issue_reg, issue_next;
    logic               rd_valid_reg, rd_valid_next;
    logic               rd_last_reg, rd_last_next;
    logic               changed_reg, changed_next;
    logic               done_reg, done_next;
    ace_rsp_t           rsp_reg, rsp_next;

    logic               accept;
    logic               query_go;
    logic               write_go;
    logic [ATTR_W-1:0]  req_left;
    logic [ATTR_W-1:0]  req_right;
    logic [CNT_W-1:0]   n_start;
    logic               last_issue;
    logic [ATTR_W-1:0]  tbl_left;
    logic [ATTR_W-1:0]  tbl_right;
    logic               applies;
    logic               grow;
    logic [ATTR_W-1:0]  clo_upd;

    function automatic ace_rsp_t make_rsp(input logic [ATTR_W-1:0] clo,
                                          input logic [ATTR_W-1:0] rhs,
                                          input logic [ATTR_FW-1:0] rel);
        ace_rsp_t r;
        r.closure_attrs = ATTR_FW'(clo);
        r.is_superkey   = (ATTR_FW'(clo) == rel);
        r.implies_right = ((rhs & ~clo) == '0);
        return r;
    endfunction

    assign busy      = (state_reg != S_IDLE);
    assign cfg_ready = 1'b1;
    assign done      = done_reg;
    assign result    = rsp_reg;

    assign accept    = start && !busy;
    assign query_go  = accept && (request.func == FUNC_QUERY);
    assign write_go  = accept && (request.func == FUNC_WRITE)
                       && (32'(request.entry_index) < DEP_DEPTH);
    assign req_left  = request.left_attrs[ATTR_W-1:0];
    assign req_right = request.right_attrs[ATTR_W-1:0];
    assign n_start   = (32'(count_reg) > DEP_DEPTH) ? CNT_W'(DEP_DEPTH)
                                                    : CNT_W'(count_reg);

    assign last_issue = (CNT_W'(idx_reg) == (n_reg - CNT_W'(1)));

    ace_dep_table #(
        .DEP_DEPTH (DEP_DEPTH),
        .ATTR_W    (ATTR_W)
    ) u_table (
        .clk      (clk),
        .wr_en    (write_go),
        .wr_addr  (ADDR_W'(request.entry_index)),
        .wr_left  (req_left),
        .wr_right (req_right),
        .rd_en    ((state_reg == S_WALK) && issue_reg),
        .rd_addr  (idx_reg),
        .rd_left  (tbl_left),
        .rd_right (tbl_right)
    );

    assign applies = ((tbl_left & ~clo_reg) == '0);
    assign grow    = rd_valid_reg && applies && ((tbl_right & ~clo_reg) != '0);
    assign clo_upd = (rd_valid_reg && applies) ? (clo_reg | tbl_right) : clo_reg;

    always_comb
    begin
        state_next    = state_reg;
        clo_next      = clo_reg;
        right_next    = right_reg;
        n_next        = n_reg;
        idx_next      = idx_reg;
        issue_next    = issue_reg;
        rd_valid_next = 1'b0;
        rd_last_next  = 1'b0;
        changed_next  = changed_reg;
        done_next     = 1'b0;
        rsp_next      = rsp_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (query_go)
                begin
                    clo_next     = req_left;
                    right_next   = req_right;
                    n_next       = n_start;
                    idx_next     = '0;
                    issue_next   = 1'b1;
                    changed_next = 1'b0;
                    if (n_start == '0)
                    begin
                        done_next = 1'b1;
                        rsp_next  = make_rsp(req_left, req_right, rel_reg);
                    end
                    else
                    begin
                        state_next = S_WALK;
                    end
                end
            end
            S_WALK:
            begin
                rd_valid_next = issue_reg;
                rd_last_next  = issue_reg && last_issue;
                if (issue_reg)
                begin
                    idx_next = idx_reg + ADDR_W'(1);
                    if (last_issue)
                    begin
                        issue_next = 1'b0;
                    end
                end
                if (rd_valid_reg)
                begin
                    clo_next     = clo_upd;
                    changed_next = changed_reg | grow;
                    if (rd_last_reg)
                    begin
                        if (changed_reg | grow)
                        begin
                            // another pass over the table
                            idx_next     = '0;
                            issue_next   = 1'b1;
                            changed_next = 1'b0;
                        end
                        else
                        begin
                            state_next = S_IDLE;
                            done_next  = 1'b1;
                            rsp_next   = make_rsp(clo_upd, right_reg, rel_reg);
                        end
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            rel_reg      <= '0;
            count_reg    <= '0;
            clo_reg      <= '0;
            right_reg    <= '0;
            n_reg        <= '0;
            idx_reg      <= '0;
            issue_reg    <= 1'b0;
            rd_valid_reg <= 1'b0;
            rd_last_reg  <= 1'b0;
            changed_reg  <= 1'b0;
            done_reg     <= 1'b0;
            rsp_reg      <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            clo_reg      <= clo_next;
            right_reg    <= right_next;
            n_reg        <= n_next;
            idx_reg      <= idx_next;
            issue_reg    <= issue_next;
            rd_valid_reg <= rd_valid_next;
            rd_last_reg  <= rd_last_next;
            changed_reg  <= changed_next;
            done_reg     <= done_next;
            rsp_reg      <= rsp_next;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    CFG_RELATION_ATTRS: rel_reg   <= cfg_data;
                    CFG_DEP_COUNT:      count_reg <= cfg_data[CNT_FW-1:0];
                    default:            ;
                endcase
            end
        end
    end

`ifndef SYNTHESIS
    a_done_source: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> ($past(state_reg) == S_WALK) || $past(query_go))
        else $error("result strobe without a query in flight");

    a_read_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
        rd_valid_reg |-> (state_reg == S_WALK))
        else $error("table read data outside the walk");

    a_closure_grows: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_WALK) && ($past(state_reg) == S_WALK))
            |-> (($past(clo_reg) & ~clo_reg) == '0))
        else $error("running closure lost attributes");

    a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !rd_valid_reg && !rd_last_reg)
        else $error("pending table read while idle");
`endif

endmodule
